@@ hw/rtl/hvp_pkg.sv @@
// ----------------------------------------------------------------------------
// hvp_pkg
// Shared widths, shift amounts and pipeline control types for the hashed
// vector projection block.
// ----------------------------------------------------------------------------
package hvp_pkg;

  localparam int TABLE_ENTRIES_DEF  = 1024;
  localparam int MAX_PARTITIONS_DEF = 64;

  localparam int HASH_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 10;
  localparam int COORD_W = 16;
  localparam int SUM_W   = 22;
  localparam int COUNT_W = 7;

  localparam int MIX_SHL   = 10;
  localparam int MIX_SHR   = 6;
  localparam int FIN_SHL_A = 3;
  localparam int FIN_SHR   = 11;
  localparam int FIN_SHL_B = 15;

  typedef enum logic [1:0] {
    ITEM_NONE,
    ITEM_WRITE,
    ITEM_PART
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic       eot;
  } item_ctl_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

endpackage

@@ hw/rtl/hvp_if.sv @@
// ----------------------------------------------------------------------------
// hvp_if
// Valid/ready channels: taxon and table-write items in, tree sums out.
// ----------------------------------------------------------------------------
interface hvp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [7:0]           taxon_byte;
  logic                        end_of_partition;
  logic                        end_of_tree;
  logic [9:0]                  entry_index;
  logic [15:0]                 entry_x;
  logic [15:0]                 entry_y;
  logic [15:0]                 entry_z;

  modport source (
    output valid, cmd, taxon_byte, end_of_partition, end_of_tree,
           entry_index, entry_x, entry_y, entry_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, taxon_byte, end_of_partition, end_of_tree,
           entry_index, entry_x, entry_y, entry_z,
    output ready
  );
endinterface

interface hvp_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] sum_x;
  logic [21:0] sum_y;
  logic [21:0] sum_z;
  logic [6:0]  partition_count;

  modport source (
    output valid, sum_x, sum_y, sum_z, partition_count,
    input  ready
  );
  modport sink (
    input  valid, sum_x, sum_y, sum_z, partition_count,
    output ready
  );
endinterface

@@ hw/rtl/hashed_vector_projection.sv @@
// ----------------------------------------------------------------------------
// hashed_vector_projection
// Hashes taxon bytes per partition, looks up a 3D table vector for each
// partition and emits the saturating sum of those vectors per tree.
//
//   channel  dir  transfer carries
//   -------  ---  -----------------------------------------------------------
//   items    in   taxon byte with partition/tree end flags, or a table write
//   sums     out  sum_x, sum_y, sum_z, partition_count at the end of a tree
//
// One item per cycle while the pipeline is not held. A tree-end byte's sums
// pass through these registers in order: the hash register loads at the
// transfer edge, then finalize, two multiplies for the modulo, the correction,
// the table read and the accumulate each add one register.
// The whole pipeline advances together; it holds only while a tree end sits
// at the accumulator and the previous result is still unaccepted, and
// items.ready follows that.
// Synchronous reset clears the hash, sums, count and pipeline valid state;
// the table contents are undefined until written.
// ----------------------------------------------------------------------------
module hashed_vector_projection #(
  parameter int TABLE_ENTRIES  = hvp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_PARTITIONS = hvp_pkg::MAX_PARTITIONS_DEF
) (
  input logic      clk,
  input logic      rst,
  hvp_in_if.sink   items,
  hvp_out_if.source sums
);
  import hvp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic              en;
  item_ctl_t         ctl_h, ctl_i, ctl_t;
  logic [HASH_W-1:0] hash_h;
  logic [IDX_W-1:0]  widx_h, idx_i;
  vec_t              wdata_h, wdata_i, rdata_t;
  vec_t              entry;

  assign en          = !sums.valid || sums.ready ||
                       !(ctl_t.kind == ITEM_PART && ctl_t.eot);
  assign items.ready = en;
  assign entry       = '{x: items.entry_x, y: items.entry_y, z: items.entry_z};

  hvp_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_hash (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (items.valid),
    .cmd              (items.cmd),
    .taxon_byte       (items.taxon_byte),
    .end_of_partition (items.end_of_partition),
    .end_of_tree      (items.end_of_tree),
    .entry_index      (items.entry_index),
    .entry            (entry),
    .ctl              (ctl_h),
    .hash             (hash_h),
    .widx             (widx_h),
    .wdata            (wdata_h)
  );

  hvp_index #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_index (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl_h),
    .hash_in  (hash_h),
    .widx_in  (widx_h),
    .wdata_in (wdata_h),
    .ctl      (ctl_i),
    .idx      (idx_i),
    .wdata    (wdata_i)
  );

  hvp_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl_in (ctl_i),
    .idx    (idx_i),
    .wdata  (wdata_i),
    .ctl    (ctl_t),
    .rdata  (rdata_t)
  );

  hvp_accum #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_accum (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .ctl             (ctl_t),
    .rdata           (rdata_t),
    .out_ready       (sums.ready),
    .out_valid       (sums.valid),
    .sum_x           (sums.sum_x),
    .sum_y           (sums.sum_y),
    .sum_z           (sums.sum_z),
    .partition_count (sums.partition_count)
  );

endmodule

@@ hw/rtl/hvp_hash.sv @@
// ----------------------------------------------------------------------------
// hvp_hash
// Input stage: folds taxon bytes into the running one-at-a-time hash and
// launches partition ends and table writes into the index pipeline.
// ----------------------------------------------------------------------------
module hvp_hash #(
  parameter int TABLE_ENTRIES = hvp_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          cmd,
  input  logic [hvp_pkg::BYTE_W-1:0]    taxon_byte,
  input  logic                          end_of_partition,
  input  logic                          end_of_tree,
  input  logic [hvp_pkg::INDEX_W-1:0]   entry_index,
  input  hvp_pkg::vec_t                 entry,
  output hvp_pkg::item_ctl_t            ctl,
  output logic [hvp_pkg::HASH_W-1:0]    hash,
  output logic [IDX_W-1:0]              widx,
  output hvp_pkg::vec_t                 wdata
);
  import hvp_pkg::*;

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  item_ctl_t         ctl_next;
  logic [HASH_W-1:0] sext;
  logic [HASH_W-1:0] h1;
  logic [HASH_W-1:0] h2;
  logic [HASH_W-1:0] h3;
  logic [31:0]       idx32;
  logic              in_range;
  logic              part_end;

  assign sext     = {{(HASH_W-BYTE_W){taxon_byte[BYTE_W-1]}}, taxon_byte};
  assign h1       = running_hash + sext;
  assign h2       = h1 + (h1 << MIX_SHL);
  assign h3       = h2 ^ (h2 >> MIX_SHR);
  assign idx32    = 32'(entry_index);
  assign in_range = idx32 < 32'(TABLE_ENTRIES);
  assign part_end = end_of_partition || end_of_tree;

  always_comb begin
    ctl_next          = '{kind: ITEM_NONE, eot: 1'b0};
    running_hash_next = running_hash;
    if (in_valid) begin
      if (cmd) begin
        if (in_range) begin
          ctl_next.kind = ITEM_WRITE;
        end
      end else begin
        running_hash_next = part_end ? '0 : h3;
        if (part_end) begin
          ctl_next.kind = ITEM_PART;
          ctl_next.eot  = end_of_tree;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      ctl          <= '{kind: ITEM_NONE, eot: 1'b0};
    end else if (en) begin
      running_hash <= running_hash_next;
      ctl          <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hash  <= h3;
      widx  <= idx32[IDX_W-1:0];
      wdata <= entry;
    end
  end

endmodule

@@ hw/rtl/hvp_index.sv @@
// ----------------------------------------------------------------------------
// hvp_index
// Finalizes the partition hash and reduces it modulo the table size by a
// reciprocal multiply, a back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module hvp_index #(
  parameter int TABLE_ENTRIES = hvp_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  hvp_pkg::item_ctl_t            ctl_in,
  input  logic [hvp_pkg::HASH_W-1:0]    hash_in,
  input  logic [IDX_W-1:0]              widx_in,
  input  hvp_pkg::vec_t                 wdata_in,
  output hvp_pkg::item_ctl_t            ctl,
  output logic [IDX_W-1:0]              idx,
  output hvp_pkg::vec_t                 wdata
);
  import hvp_pkg::*;

  localparam logic [63:0]       RECIP64 = 64'h1_0000_0000 / 64'(TABLE_ENTRIES);
  localparam logic [HASH_W-1:0] RECIP   = RECIP64[HASH_W-1:0];
  localparam logic [HASH_W-1:0] DIVISOR = HASH_W'(TABLE_ENTRIES);

  item_ctl_t           ctl_b, ctl_c, ctl_d;
  logic [HASH_W-1:0]   fin_b, fin_c, fin_d;
  logic [2*HASH_W-1:0] prod_c;
  logic [HASH_W-1:0]   qd_d;
  logic [IDX_W-1:0]    widx_b, widx_c, widx_d;
  vec_t                wdata_b, wdata_c, wdata_d;

  logic [HASH_W-1:0]   f1, f2, f3;
  logic [2*HASH_W-1:0] prod_next;
  logic [HASH_W-1:0]   qd_next;
  logic [HASH_W-1:0]   diff;
  logic [HASH_W-1:0]   rem;

  assign f1        = hash_in + (hash_in << FIN_SHL_A);
  assign f2        = f1 ^ (f1 >> FIN_SHR);
  assign f3        = f2 + (f2 << FIN_SHL_B);
  assign prod_next = {HASH_W'(0), fin_b} * {HASH_W'(0), RECIP};
  assign qd_next   = prod_c[2*HASH_W-1:HASH_W] * DIVISOR;
  assign diff      = fin_d - qd_d;
  assign rem       = (diff >= DIVISOR) ? (diff - DIVISOR) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '{kind: ITEM_NONE, eot: 1'b0};
      ctl_c <= '{kind: ITEM_NONE, eot: 1'b0};
      ctl_d <= '{kind: ITEM_NONE, eot: 1'b0};
      ctl   <= '{kind: ITEM_NONE, eot: 1'b0};
    end else if (en) begin
      ctl_b <= ctl_in;
      ctl_c <= ctl_b;
      ctl_d <= ctl_c;
      ctl   <= ctl_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_b   <= f3;
      widx_b  <= widx_in;
      wdata_b <= wdata_in;
      fin_c   <= fin_b;
      prod_c  <= prod_next;
      widx_c  <= widx_b;
      wdata_c <= wdata_b;
      fin_d   <= fin_c;
      qd_d    <= qd_next;
      widx_d  <= widx_c;
      wdata_d <= wdata_c;
      idx     <= (ctl_d.kind == ITEM_WRITE) ? widx_d : rem[IDX_W-1:0];
      wdata   <= wdata_d;
    end
  end

endmodule

@@ hw/rtl/hvp_table.sv @@
// ----------------------------------------------------------------------------
// hvp_table
// Coordinate table memory: writes and partition lookups reach it in stream
// order through the same stage.
// ----------------------------------------------------------------------------
module hvp_table #(
  parameter int TABLE_ENTRIES = hvp_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hvp_pkg::item_ctl_t  ctl_in,
  input  logic [IDX_W-1:0]    idx,
  input  hvp_pkg::vec_t       wdata,
  output hvp_pkg::item_ctl_t  ctl,
  output hvp_pkg::vec_t       rdata
);
  import hvp_pkg::*;

  vec_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_in.kind == ITEM_WRITE) begin
        mem[idx] <= wdata;
      end
      if (ctl_in.kind == ITEM_PART) begin
        rdata <= mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '{kind: ITEM_NONE, eot: 1'b0};
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

endmodule

@@ hw/rtl/hvp_accum.sv @@
// ----------------------------------------------------------------------------
// hvp_accum
// Saturating 3D running sum and partition count; loads the result register
// at the end of a tree and clears the sums.
// ----------------------------------------------------------------------------
module hvp_accum #(
  parameter int MAX_PARTITIONS = hvp_pkg::MAX_PARTITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  hvp_pkg::item_ctl_t            ctl,
  input  hvp_pkg::vec_t                 rdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [hvp_pkg::SUM_W-1:0]     sum_x,
  output logic [hvp_pkg::SUM_W-1:0]     sum_y,
  output logic [hvp_pkg::SUM_W-1:0]     sum_z,
  output logic [hvp_pkg::COUNT_W-1:0]   partition_count
);
  import hvp_pkg::*;

  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    COUNT_W'((MAX_PARTITIONS > COUNT_MAX) ? COUNT_MAX : MAX_PARTITIONS);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  logic [SUM_W-1:0]   acc_x, acc_y, acc_z;
  logic [COUNT_W-1:0] parts_seen;
  logic [SUM_W:0]     raw_x, raw_y, raw_z;
  logic [SUM_W-1:0]   acc_x_next, acc_y_next, acc_z_next;
  logic [COUNT_W-1:0] parts_seen_next;
  logic               part;

  assign raw_x = {1'b0, acc_x} + (SUM_W+1)'(rdata.x);
  assign raw_y = {1'b0, acc_y} + (SUM_W+1)'(rdata.y);
  assign raw_z = {1'b0, acc_z} + (SUM_W+1)'(rdata.z);
  assign acc_x_next = raw_x[SUM_W] ? SUM_MAX : raw_x[SUM_W-1:0];
  assign acc_y_next = raw_y[SUM_W] ? SUM_MAX : raw_y[SUM_W-1:0];
  assign acc_z_next = raw_z[SUM_W] ? SUM_MAX : raw_z[SUM_W-1:0];
  assign parts_seen_next = (parts_seen < COUNT_CAP) ? parts_seen + 1'b1 : parts_seen;
  assign part = en && (ctl.kind == ITEM_PART);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x      <= '0;
      acc_y      <= '0;
      acc_z      <= '0;
      parts_seen <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (part && ctl.eot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (part) begin
        if (ctl.eot) begin
          acc_x      <= '0;
          acc_y      <= '0;
          acc_z      <= '0;
          parts_seen <= '0;
        end else begin
          acc_x      <= acc_x_next;
          acc_y      <= acc_y_next;
          acc_z      <= acc_z_next;
          parts_seen <= parts_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part && ctl.eot) begin
      sum_x           <= acc_x_next;
      sum_y           <= acc_y_next;
      sum_z           <= acc_z_next;
      partition_count <= parts_seen_next;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks hashed_vector_projection against a cycle-free predictor of the
// taxon hash, table lookup and saturating tree sums. Directed trees cover
// byte extremes, ignored flags on writes, tree end without partition end,
// rewrites of a slot just before it is read, sum and count saturation and a
// long output stall; random trees with random gaps on both channels follow.
// Every partition end is preceded by a write to its slot if that slot was
// never loaded.
// ----------------------------------------------------------------------------
module testbench;
  import hvp_pkg::*;

  localparam logic CMD_TAXON = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int COUNT_CAP     = (MAX_PARTITIONS_DEF > 127) ? 127 : MAX_PARTITIONS_DEF;
  localparam int RANDOM_ITEMS  = 330;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic                  cmd;
    logic [BYTE_W-1:0]     taxon;
    logic                  eop;
    logic                  eot;
    logic [INDEX_W-1:0]    idx;
    coord_t                ex;
    coord_t                ey;
    coord_t                ez;
  } taxon_item_t;

  typedef struct {
    logic [SUM_W-1:0]   sx;
    logic [SUM_W-1:0]   sy;
    logic [SUM_W-1:0]   sz;
    logic [COUNT_W-1:0] count;
  } tree_sums_t;

  logic clk = 1'b0;
  logic rst;

  hvp_in_if  items_if ();
  hvp_out_if sums_if ();

  hashed_vector_projection dut (
    .clk   (clk),
    .rst   (rst),
    .items (items_if),
    .sums  (sums_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [HASH_W-1:0]  tree_hash = '0;
  logic [SUM_W-1:0]   acc_x = '0;
  logic [SUM_W-1:0]   acc_y = '0;
  logic [SUM_W-1:0]   acc_z = '0;
  logic [COUNT_W-1:0] parts_acc = '0;
  coord_t             table_x [TABLE_ENTRIES_DEF];
  coord_t             table_y [TABLE_ENTRIES_DEF];
  coord_t             table_z [TABLE_ENTRIES_DEF];
  bit                 slot_loaded [TABLE_ENTRIES_DEF];

  tree_sums_t  expected_sums [$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  bit          hold_sums = 1'b0;

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] m;
    m = h + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    m = m + (m << MIX_SHL);
    m = m ^ (m >> MIX_SHR);
    return m;
  endfunction

  function automatic logic [INDEX_W-1:0] table_slot(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] f;
    f = h + (h << FIN_SHL_A);
    f = f ^ (f >> FIN_SHR);
    f = f + (f << FIN_SHL_B);
    return INDEX_W'(f % TABLE_ENTRIES_DEF);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a, input coord_t v);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(v);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic void predict_projection(input taxon_item_t it);
    logic [INDEX_W-1:0] slot;
    tree_sums_t         r;
    if (it.cmd == CMD_WRITE) begin
      table_x[it.idx] = it.ex;
      table_y[it.idx] = it.ey;
      table_z[it.idx] = it.ez;
      slot_loaded[it.idx] = 1'b1;
      return;
    end
    tree_hash = mix_byte(tree_hash, it.taxon);
    if (!it.eop && !it.eot) return;
    slot = table_slot(tree_hash);
    tree_hash = '0;
    acc_x = sat_sum(acc_x, table_x[slot]);
    acc_y = sat_sum(acc_y, table_y[slot]);
    acc_z = sat_sum(acc_z, table_z[slot]);
    if (parts_acc < COUNT_W'(COUNT_CAP)) parts_acc++;
    if (!it.eot) return;
    r.sx = acc_x;
    r.sy = acc_y;
    r.sz = acc_z;
    r.count = parts_acc;
    expected_sums.push_back(r);
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    parts_acc = '0;
  endfunction

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(15))
      0: return coord_t'($urandom);
      1: return 16'd32768;
      default: return coord_t'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic taxon_item_t random_write(input logic [INDEX_W-1:0] slot);
    taxon_item_t it;
    it.cmd   = CMD_WRITE;
    it.taxon = BYTE_W'($urandom);
    it.eop   = 1'($urandom);
    it.eot   = 1'($urandom);
    it.idx   = slot;
    it.ex    = random_coord();
    it.ey    = random_coord();
    it.ez    = random_coord();
    return it;
  endfunction

  function automatic taxon_item_t taxon_item(input logic [BYTE_W-1:0] b,
                                             input logic eop, input logic eot);
    taxon_item_t it;
    it       = random_write(INDEX_W'($urandom));
    it.cmd   = CMD_TAXON;
    it.taxon = b;
    it.eop   = eop;
    it.eot   = eot;
    return it;
  endfunction

  function automatic taxon_item_t coord_write(input logic [INDEX_W-1:0] slot,
                                              input coord_t v, input logic flags);
    taxon_item_t it;
    it     = random_write(slot);
    it.eop = flags;
    it.eot = flags;
    it.ex  = v;
    it.ey  = v;
    it.ez  = v;
    return it;
  endfunction

  task automatic push_item(input taxon_item_t it);
    int unsigned gap;
    gap = pick_gap(src_idle);
    if (gap != 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid            <= 1'b1;
    items_if.cmd              <= it.cmd;
    items_if.taxon_byte       <= it.taxon;
    items_if.end_of_partition <= it.eop;
    items_if.end_of_tree      <= it.eot;
    items_if.entry_index      <= it.idx;
    items_if.entry_x          <= it.ex;
    items_if.entry_y          <= it.ey;
    items_if.entry_z          <= it.ez;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    predict_projection(it);
  endtask

  // loads the slot a closing byte will read if it was never written
  task automatic send_item(input taxon_item_t it);
    logic [INDEX_W-1:0] slot;
    if (it.cmd == CMD_TAXON && (it.eop || it.eot)) begin
      slot = table_slot(mix_byte(tree_hash, it.taxon));
      if (!slot_loaded[slot]) push_item(random_write(slot));
    end
    push_item(it);
  endtask

  task automatic drain_sums();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_items();
    logic [INDEX_W-1:0] slot;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_item(coord_write('0, 16'h0000, 1'b1));
    send_item(coord_write('1, 16'hFFFF, 1'b0));
    send_item(coord_write(10'd512, 16'd32768, 1'b1));
    send_item(taxon_item(8'h80, 1'b1, 1'b0));
    send_item(taxon_item(8'h7F, 1'b1, 1'b0));
    send_item(taxon_item(8'h00, 1'b1, 1'b1));
    send_item(taxon_item(8'd1, 1'b0, 1'b0));
    send_item(taxon_item(8'd2, 1'b0, 1'b0));
    send_item(taxon_item(8'd3, 1'b1, 1'b0));
    send_item(taxon_item(8'd9, 1'b0, 1'b0));
    send_item(taxon_item(8'hFF, 1'b0, 1'b0));
    send_item(taxon_item(8'hFE, 1'b0, 1'b1));
    send_item(taxon_item(8'd10, 1'b0, 1'b0));
    send_item(random_write(INDEX_W'($urandom)));
    send_item(taxon_item(8'd11, 1'b1, 1'b1));
    slot = table_slot(mix_byte('0, 8'd5));
    send_item(random_write(slot));
    send_item(taxon_item(8'd5, 1'b1, 1'b0));
    send_item(random_write(slot));
    send_item(taxon_item(8'd5, 1'b1, 1'b1));
  endtask

  task automatic test_saturation();
    int unsigned n;
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    n = COUNT_CAP + 3;
    send_item(coord_write(table_slot(mix_byte('0, 8'h7F)), 16'hFFFF, 1'b0));
    for (int p = 0; p < n; p++) send_item(taxon_item(8'h7F, 1'b1, p == n - 1));
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_sums = 1'b1;
    for (int t = 0; t < 12; t++) begin
      if ($urandom_range(1)) send_item(taxon_item(BYTE_W'($urandom), 1'b0, 1'b0));
      send_item(taxon_item(BYTE_W'($urandom), 1'b1, 1'b1));
    end
  endtask

  task automatic test_random_trees();
    int unsigned sent;
    int unsigned n_parts;
    int unsigned n_bytes;
    logic        last;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle  = ($urandom_range(3) != 0);
      sink_idle = ($urandom_range(3) != 0);
      n_parts = ($urandom_range(15) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int p = 0; p < n_parts; p++) begin
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
        for (int b = 0; b < n_bytes; b++) begin
          if ($urandom_range(9) == 0) begin
            send_item(random_write(INDEX_W'($urandom)));
            sent++;
          end
          last = (b == n_bytes - 1);
          if (last && p == n_parts - 1)
            send_item(taxon_item(BYTE_W'($urandom), $urandom_range(3) != 0, 1'b1));
          else
            send_item(taxon_item(BYTE_W'($urandom), last, 1'b0));
          sent++;
        end
      end
    end
  endtask

  initial begin : sums_sink
    int unsigned stall_left;
    stall_left = 0;
    sums_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sums) begin
        stall_left = HOLD_CYCLES;
        hold_sums  = 1'b0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(sink_idle);
      end
      if (stall_left != 0) begin
        sums_if.ready <= 1'b0;
        stall_left--;
      end else begin
        sums_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : sums_check
    tree_sums_t want;
    if (!rst && sums_if.valid && sums_if.ready) begin
      if (expected_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual x=%0d y=%0d z=%0d count=%0d",
                 $time, sums_if.sum_x, sums_if.sum_y, sums_if.sum_z,
                 sums_if.partition_count);
      end else begin
        want = expected_sums.pop_front();
        check_field("sum_x", 32'(want.sx), 32'(sums_if.sum_x));
        check_field("sum_y", 32'(want.sy), 32'(sums_if.sum_y));
        check_field("sum_z", 32'(want.sz), 32'(sums_if.sum_z));
        check_field("partition_count", 32'(want.count), 32'(sums_if.partition_count));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst                       = 1'b1;
    items_if.valid            = 1'b0;
    items_if.cmd              = CMD_TAXON;
    items_if.taxon_byte       = '0;
    items_if.end_of_partition = 1'b0;
    items_if.end_of_tree      = 1'b0;
    items_if.entry_index      = '0;
    items_if.entry_x          = '0;
    items_if.entry_y          = '0;
    items_if.entry_z          = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_items();
    drain_sums();
    test_saturation();
    drain_sums();
    test_backpressure();
    drain_sums();
    test_random_trees();
    drain_sums();
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
